FILE: hdl/rfa_pkg.sv
// Package for the register file ALU: sizes, command codes, the controller to
// datapath command and status structs, and register index helpers.
// No dependencies.
package rfa_pkg;

    localparam int NUM_REGS  = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 4;
    localparam int CMD_W     = 4;
    localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int WIDE_W    = IDX_W + REG_AW;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [CMD_W-1:0] {
        OP_LOAD = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_REM  = 4'd5,
        OP_OR   = 4'd6,
        OP_NOT  = 4'd7,
        OP_EQ   = 4'd8,
        OP_GT   = 4'd9,
        OP_COPY = 4'd10,
        OP_READ = 4'd11
    } t_op;

    typedef struct packed {
        t_op  op;
        logic capture;
        logic rd_dest;
        logic exec;
        logic div_step;
        logic div_fix;
        logic dest_latch;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic b_zero;
        logic or_zero;
    } t_dp_sts;

    function automatic logic [REG_AW-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
        logic [WIDE_W-1:0] wide;
        wide = {{REG_AW{1'b0}}, idx};
        return wide[REG_AW-1:0];
    endfunction

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        logic [WIDE_W-1:0] wide;
        wide = {{REG_AW{1'b0}}, idx};
        return wide < WIDE_W'(NUM_REGS);
    endfunction

endpackage

FILE: hdl/rfa_ram.sv
// Generic RAM: one write port and two read ports, registered read data.
// No dependencies.
module rfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                      o_rdata_a,
    output logic [WIDTH-1:0]                      o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: hdl/rfa_datapath.sv
// Datapath: register file RAM with reset valid bits, ALU, bit-serial signed
// divider and output register. Depends on rfa_pkg and rfa_ram.
module rfa_datapath
    import rfa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd_bus,
    input  logic [IDX_W-1:0]         i_src_a,
    input  logic [IDX_W-1:0]         i_src_b,
    input  logic [IDX_W-1:0]         i_dest,
    input  logic signed [DATA_W-1:0] i_imm_value,
    output t_dp_sts                  o_sts,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                     o_div_zero
);

    logic [IDX_W-1:0]    r_ia, r_ib, r_id;
    logic [DATA_W-1:0]   r_imm;
    logic [NUM_REGS-1:0] r_valid;
    logic                r_va, r_vb;
    logic [DATA_W-1:0]   r_res;
    logic                r_dz, r_wen;
    logic                r_sa, r_sb;
    logic [DATA_W-1:0]   r_rem, r_quo, r_dvs;
    logic [DATA_W-1:0]   r_out_value;
    logic                r_out_dz;

    logic [IDX_W-1:0]    rd_idx_a;
    logic [REG_AW-1:0]   raddr_a, raddr_b, waddr;
    logic [DATA_W-1:0]   rdata_a, rdata_b;
    logic [DATA_W-1:0]   a, b, ma, mb, mul_lo, alu_res;
    logic                wr_ok, we;
    logic [IDX_W-1:0]    w_idx;
    logic [DATA_W:0]     trial;
    logic [DATA_W-1:0]   quo_fix, rem_fix;

    assign rd_idx_a = i_cmd_bus.rd_dest ? r_id : r_ia;
    assign raddr_a  = idx_to_addr(rd_idx_a);
    assign raddr_b  = idx_to_addr(r_ib);

    assign w_idx = (i_cmd_bus.op == OP_LOAD || i_cmd_bus.op == OP_NOT) ? r_ia : r_id;
    assign waddr = idx_to_addr(w_idx);
    assign we    = i_cmd_bus.finish & r_wen & idx_in_range(w_idx);

    rfa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (r_res),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign a      = r_va ? rdata_a : '0;
    assign b      = r_vb ? rdata_b : '0;
    assign ma     = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
    assign mb     = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
    assign mul_lo = a * b;

    assign o_sts.b_zero  = (b == '0);
    assign o_sts.or_zero = (a == '0) && (b == '0);

    always_comb begin
        alu_res = '0;
        wr_ok   = 1'b0;
        unique case (i_cmd_bus.op)
            OP_LOAD: begin alu_res = r_imm;                         wr_ok = 1'b1; end
            OP_ADD:  begin alu_res = a + b;                         wr_ok = 1'b1; end
            OP_SUB:  begin alu_res = a - b;                         wr_ok = 1'b1; end
            OP_MUL:  begin alu_res = mul_lo;                        wr_ok = 1'b1; end
            OP_DIV,
            OP_REM:  begin alu_res = '0;                 wr_ok = (b != '0); end
            OP_OR:   begin alu_res = DATA_W'(1);         wr_ok = !o_sts.or_zero; end
            OP_NOT:  begin alu_res = DATA_W'(a == '0);              wr_ok = 1'b1; end
            OP_EQ:   begin alu_res = DATA_W'(a == b);               wr_ok = 1'b1; end
            OP_GT:   begin alu_res = DATA_W'($signed(a) > $signed(b)); wr_ok = 1'b1; end
            OP_COPY: begin alu_res = a;                             wr_ok = 1'b1; end
            OP_READ: begin alu_res = a;                             wr_ok = 1'b0; end
            default: begin alu_res = '0;                            wr_ok = 1'b0; end
        endcase
    end

    assign trial   = {r_rem, r_quo[DATA_W-1]} - {1'b0, r_dvs};
    assign quo_fix = (r_sa ^ r_sb) ? (~r_quo + DATA_W'(1)) : r_quo;
    assign rem_fix = r_sa ? (~r_rem + DATA_W'(1)) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va <= idx_in_range(rd_idx_a) & r_valid[raddr_a];
        r_vb <= idx_in_range(r_ib) & r_valid[raddr_b];
        if (i_cmd_bus.capture) begin
            r_ia  <= i_src_a;
            r_ib  <= i_src_b;
            r_id  <= i_dest;
            r_imm <= i_imm_value;
        end
        if (i_cmd_bus.exec) begin
            r_res <= alu_res;
            r_dz  <= (i_cmd_bus.op == OP_DIV || i_cmd_bus.op == OP_REM) && o_sts.b_zero;
            r_wen <= wr_ok;
            r_sa  <= a[DATA_W-1];
            r_sb  <= b[DATA_W-1];
            r_rem <= '0;
            r_quo <= ma;
            r_dvs <= mb;
        end
        if (i_cmd_bus.div_step) begin
            if (!trial[DATA_W]) begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
        if (i_cmd_bus.div_fix) begin
            r_res <= (i_cmd_bus.op == OP_DIV) ? quo_fix : rem_fix;
        end
        if (i_cmd_bus.dest_latch) begin
            r_res <= a;
        end
        if (i_cmd_bus.finish) begin
            r_out_value <= r_res;
            r_out_dz    <= r_dz;
        end
    end

    assign o_result_value = r_out_value;
    assign o_div_zero     = r_out_dz;

endmodule

FILE: hdl/rfa_ctrl.sv
// Controller: sequences one command at a time through register read, ALU,
// divider iterations and the output handshake. Depends on rfa_pkg.
module rfa_ctrl
    import rfa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_ready,
    input  t_dp_sts          i_sts,
    output logic             o_ready,
    output logic             o_valid,
    output t_dp_cmd          o_cmd_bus
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_FIX,
        S_DREAD,
        S_DLATCH,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CMD_W-1:0] r_op, n_op;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_op              op;

    assign op = t_op'(r_op);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cnt       = r_cnt;
        o_cmd_bus   = '0;
        o_cmd_bus.op = op;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd_bus.capture = 1'b1;
                    n_op    = i_cmd;
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                o_cmd_bus.exec = 1'b1;
                n_cnt = '0;
                if (op == OP_DIV || op == OP_REM) begin
                    n_state = i_sts.b_zero ? S_DONE : S_DIV;
                end else if (op == OP_OR && i_sts.or_zero) begin
                    n_state = S_DREAD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd_bus.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd_bus.div_fix = 1'b1;
                n_state = S_DONE;
            end
            S_DREAD: begin
                o_cmd_bus.rd_dest = 1'b1;
                n_state = S_DLATCH;
            end
            S_DLATCH: begin
                o_cmd_bus.dest_latch = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd_bus.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd_bus.finish | (r_out_valid & ~i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: hdl/register_file_alu_top.sv
// Register file ALU top level: 16 signed 32-bit registers, one command per
// input transaction, one result per command. Depends on rfa_pkg, rfa_ctrl, rfa_datapath.
//
// Commands run one at a time. Most go from acceptance through register read and ALU
// execute to the output register load. Logical OR with both sources zero adds a
// destination read and latch, and divide or remainder with a nonzero divisor run the
// one-bit-per-cycle divider (32 steps plus sign fix) before the output load. A command
// holds in its last cycle while the previous result still waits in the output
// register. The next command is taken the cycle after a command completes, at the
// earliest. Registers read as zero after reset through per-register valid bits; no
// clearing pass.
module register_file_alu_top
    import rfa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [IDX_W-1:0]         i_src_a,
    input  logic [IDX_W-1:0]         i_src_b,
    input  logic [IDX_W-1:0]         i_dest,
    input  logic signed [DATA_W-1:0] i_imm_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                     o_div_zero
);

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    rfa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_cmd     (i_cmd),
        .i_ready   (i_ready),
        .i_sts     (s_sts),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .o_cmd_bus (s_cmd)
    );

    rfa_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (s_cmd),
        .i_src_a        (i_src_a),
        .i_src_b        (i_src_b),
        .i_dest         (i_dest),
        .i_imm_value    (i_imm_value),
        .o_sts          (s_sts),
        .o_result_value (o_result_value),
        .o_div_zero     (o_div_zero)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.finish |-> (!o_valid || i_ready))
        else $error("result register overwritten while held");

    a_dz_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (o_result_value == '0))
        else $error("divide by zero result carries a value");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second transaction accepted while busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("not idle after reset");

endmodule
